FILE: rtl/prmc_pkg.sv
// shared types and constants for the photon recovery momentum correction block
package prmc_pkg;

  // item kinds
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_CORRECT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_ENERGY = 2'd0;
  localparam logic [1:0] REG_COS_LIMIT  = 2'd1;
  localparam logic [1:0] REG_ADD_ALL    = 2'd2;

  // register reset values
  localparam logic [22:0] MIN_ENERGY_RST = 23'd50;
  localparam logic [17:0] COS_LIMIT_RST  = 18'd130908;

  // cosine of zero angle in the limit's fixed point
  localparam logic [17:0] COS_ONE = 18'd131072;

  // widths of the cfg data and the wide accumulator
  localparam int CFG_DW = 23;
  localparam int ACC_W  = 160;

endpackage

FILE: rtl/photon_recovery_momentum_correction.sv
// photon store and iterative momentum correction using one shared multiplier
//
//  channel  | ports                                       | handshake
//  ---------+---------------------------------------------+---------------------------
//  input    | start_i busy_o kind_i energy_i mom_*_i      | start_i high, busy_o low
//  result   | result_valid_o corrected_*_o photons_*_o    | one-cycle strobe
//  config   | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | valid and ready high
//
// clear and append items never raise busy_o.
// a correction holds busy_o through the setup products, a visit to each stored photon
// (an energy check alone below the energy cut, up to a nearest-photon compare) and S_FIN.
// every wide product runs through one 33x33 multiplier one 32-bit limb pair a cycle.
// reset (rst_ni low) empties the store and loads the register defaults; no clearing pass.
// the result strobe comes with busy_o low and cannot be held off by the receiver.
module photon_recovery_momentum_correction #(
  parameter int PHOTONS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  kind_i,
  input  logic [22:0]                 energy_i,
  input  logic signed [23:0]          mom_x_i,
  input  logic signed [23:0]          mom_y_i,
  input  logic signed [23:0]          mom_z_i,
  output logic                        result_valid_o,
  output logic [29:0]                 corrected_energy_o,
  output logic signed [30:0]          corrected_x_o,
  output logic signed [30:0]          corrected_y_o,
  output logic signed [30:0]          corrected_z_o,
  output logic [6:0]                  photons_added_o,
  output logic                        store_overflowed_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [prmc_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int CW  = $clog2(PHOTONS + 1);
  localparam int AW  = (PHOTONS > 1) ? $clog2(PHOTONS) : 1;
  localparam int MWR = $clog2(PHOTONS + 2) + 25;
  localparam int MW  = (MWR > 32) ? MWR : 32;
  localparam int XW  = (CW > 7) ? CW : 7;
  localparam int AC  = prmc_pkg::ACC_W;

  localparam logic signed [MW-1:0] SMAX = MW'(1073741823);
  localparam logic signed [MW-1:0] SMIN = ~SMAX;
  localparam logic [MW-1:0]        EMAX = MW'(1073741823);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MUL, S_DRAIN, S_POST, S_RD, S_CHK, S_TAKE, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_PN2, OP_C2, OP_T, OP_GN2, OP_DOT, OP_NUM, OP_RHS, OP_CMP1, OP_CMP2
  } op_e;

  typedef struct packed {
    logic [22:0]        e;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } photon_t;

  // photon store
  photon_t mem [PHOTONS];
  photon_t rd_q;
  logic    mem_we;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [1:0] i_q, i_d;
  logic       j_q, j_d;
  logic [AC-1:0] acc_q, acc_d, lhs_q, lhs_d;
  logic signed [65:0] prod_q, prod_d;
  logic [1:0] pshift_q, pshift_d;
  logic       pval_q, pval_d;
  logic [95:0] opa_q, opa_d, t_q, t_d, num_q, num_d, bnum_q, bnum_d;
  logic [63:0] opb_q, opb_d;
  logic signed [23:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [47:0] pn2_q, pn2_d, gn2_q, gn2_d, den_q, den_d, bden_q, bden_d;
  logic        have_q, have_d;
  photon_t     best_q, best_d;
  logic [MW-1:0] se_q, se_d;
  logic signed [MW-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [CW-1:0] added_q, added_d, idx_q, idx_d, cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [22:0] min_q, min_d;
  logic [17:0] lim_q, lim_d;
  logic        all_q, all_d;
  logic        rv_q, rv_d;
  logic [29:0] oe_q, oe_d;
  logic signed [30:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [6:0]  on_q, on_d;
  logic        oo_q, oo_d;

  // multiplier operands
  logic signed [23:0] u, v;
  logic signed [32:0] a_op, b_op;
  logic [AC-1:0]      addend;
  logic signed [49:0] dot;
  // final sums
  logic [MW-1:0]        fe;
  logic signed [MW-1:0] fx, fy, fz;
  logic [CW-1:0]        fn;
  logic [XW-1:0]        fn_x;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign dot         = acc_q[49:0];

  // component pair for the three-term sums
  always_comb begin
    u = px_q;
    v = px_q;
    unique case (op_q)
      OP_PN2: begin
        u = (i_q == 2'd0) ? px_q : (i_q == 2'd1) ? py_q : pz_q;
        v = u;
      end
      OP_GN2: begin
        u = (i_q == 2'd0) ? rd_q.x : (i_q == 2'd1) ? rd_q.y : rd_q.z;
        v = u;
      end
      default: begin
        u = (i_q == 2'd0) ? px_q : (i_q == 2'd1) ? py_q : pz_q;
        v = (i_q == 2'd0) ? rd_q.x : (i_q == 2'd1) ? rd_q.y : rd_q.z;
      end
    endcase
  end

  // shared multiplier and accumulator addend
  always_comb begin
    if (state_q == S_SUM) begin
      a_op = 33'(u);
      b_op = 33'(v);
    end else begin
      a_op = {1'b0, opa_q[32*i_q +: 32]};
      b_op = {1'b0, opb_q[32*j_q +: 32]};
    end
    prod_d   = a_op * b_op;
    pshift_d = (state_q == S_SUM) ? 2'd0 : (i_q + {1'b0, j_q});
    pval_d   = (state_q == S_SUM) || (state_q == S_MUL);
    addend   = AC'(prod_q) << {pshift_q, 5'b0};
  end

  // final four-vector, with the nearest photon folded in unless all passing photons were added
  always_comb begin
    fe = se_q;
    fx = sx_q;
    fy = sy_q;
    fz = sz_q;
    fn = added_q;
    if (!all_q && have_q) begin
      fe = se_q + MW'(best_q.e);
      fx = sx_q + MW'(best_q.x);
      fy = sy_q + MW'(best_q.y);
      fz = sz_q + MW'(best_q.z);
      fn = CW'(1);
    end
    fn_x = XW'(fn);
  end

  // sequencer
  always_comb begin
    state_d = state_q;  op_d = op_q;  i_d = i_q;  j_d = j_q;
    acc_d = pval_q ? (acc_q + addend) : acc_q;
    lhs_d = lhs_q;  opa_d = opa_q;  opb_d = opb_q;  t_d = t_q;
    num_d = num_q;  bnum_d = bnum_q;  den_d = den_q;  bden_d = bden_q;
    px_d = px_q;  py_d = py_q;  pz_d = pz_q;
    pn2_d = pn2_q;  gn2_d = gn2_q;
    have_d = have_q;  best_d = best_q;
    se_d = se_q;  sx_d = sx_q;  sy_d = sy_q;  sz_d = sz_q;
    added_d = added_q;  idx_d = idx_q;  cnt_d = cnt_q;  ovf_d = ovf_q;
    min_d = min_q;  lim_d = lim_q;  all_d = all_q;
    rv_d = 1'b0;
    oe_d = oe_q;  ox_d = ox_q;  oy_d = oy_q;  oz_d = oz_q;  on_d = on_q;  oo_d = oo_q;
    mem_we = 1'b0;

    // configuration write
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        prmc_pkg::REG_MIN_ENERGY: min_d = cfg_data_i[22:0];
        prmc_pkg::REG_COS_LIMIT:  lim_d = cfg_data_i[17:0];
        prmc_pkg::REG_ADD_ALL:    all_d = cfg_data_i[0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (kind_i)
            prmc_pkg::KIND_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            prmc_pkg::KIND_APPEND: begin
              if (cnt_q < CW'(PHOTONS)) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            prmc_pkg::KIND_CORRECT: begin
              px_d = mom_x_i;  py_d = mom_y_i;  pz_d = mom_z_i;
              se_d = MW'(energy_i);
              sx_d = MW'(mom_x_i);  sy_d = MW'(mom_y_i);  sz_d = MW'(mom_z_i);
              added_d = '0;  have_d = 1'b0;  idx_d = '0;
              op_d = OP_PN2;  i_d = '0;  acc_d = '0;
              state_d = S_SUM;
            end
            default: ;
          endcase
        end
      end

      // three signed component products
      S_SUM: begin
        if (i_q == 2'd2) begin
          i_d = '0;
          state_d = S_DRAIN;
        end else begin
          i_d = i_q + 2'd1;
        end
      end

      // 96 x 64 bit product, one limb pair a cycle
      S_MUL: begin
        if (j_q) begin
          j_d = 1'b0;
          if (i_q == 2'd2) begin
            i_d = '0;
            state_d = S_DRAIN;
          end else begin
            i_d = i_q + 2'd1;
          end
        end else begin
          j_d = 1'b1;
        end
      end

      S_DRAIN: state_d = S_POST;

      S_POST: begin
        acc_d = '0;
        i_d = '0;
        j_d = 1'b0;
        unique case (op_q)
          OP_PN2: begin
            pn2_d = acc_q[47:0];
            opa_d = 96'(lim_q);  opb_d = 64'(lim_q);
            op_d = OP_C2;  state_d = S_MUL;
          end
          OP_C2: begin
            opa_d = 96'(pn2_q);  opb_d = 64'(acc_q[35:0]);
            op_d = OP_T;  state_d = S_MUL;
          end
          OP_T: begin
            t_d = acc_q[95:0];
            state_d = S_RD;
          end
          OP_GN2: begin
            gn2_d = acc_q[47:0];
            if ((pn2_q == '0) || (acc_q[47:0] == '0)) begin
              // zero momentum counts as angle zero
              num_d = 96'(pn2_q);
              den_d = 48'd1;
              if (lim_q < prmc_pkg::COS_ONE) begin
                state_d = S_TAKE;
              end else begin
                idx_d = idx_q + CW'(1);
                state_d = S_RD;
              end
            end else begin
              op_d = OP_DOT;  state_d = S_SUM;
            end
          end
          OP_DOT: begin
            if (dot[49] || (dot == '0)) begin
              idx_d = idx_q + CW'(1);
              state_d = S_RD;
            end else begin
              opa_d = 96'(dot[47:0]);  opb_d = 64'(dot[47:0]);
              den_d = gn2_q;
              op_d = OP_NUM;  state_d = S_MUL;
            end
          end
          OP_NUM: begin
            num_d = acc_q[95:0];
            opa_d = t_q;  opb_d = 64'(gn2_q);
            op_d = OP_RHS;  state_d = S_MUL;
          end
          OP_RHS: begin
            if ({30'd0, num_q, 34'd0} > acc_q) begin
              state_d = S_TAKE;
            end else begin
              idx_d = idx_q + CW'(1);
              state_d = S_RD;
            end
          end
          OP_CMP1: begin
            lhs_d = acc_q;
            opa_d = bnum_q;  opb_d = 64'(den_q);
            op_d = OP_CMP2;  state_d = S_MUL;
          end
          OP_CMP2: begin
            if (lhs_q > acc_q) begin
              bnum_d = num_q;  bden_d = den_q;  best_d = rd_q;
            end
            idx_d = idx_q + CW'(1);
            state_d = S_RD;
          end
          default: state_d = S_RD;
        endcase
      end

      // fetch the next stored photon, or finish once every stored photon was visited
      S_RD: begin
        if (idx_q == cnt_q) begin
          state_d = S_FIN;
        end else begin
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        if (rd_q.e < min_q) begin
          idx_d = idx_q + CW'(1);
          state_d = S_RD;
        end else begin
          acc_d = '0;  i_d = '0;
          op_d = OP_GN2;  state_d = S_SUM;
        end
      end

      // photon passed the cuts
      S_TAKE: begin
        if (all_q) begin
          se_d = se_q + MW'(rd_q.e);
          sx_d = sx_q + MW'(rd_q.x);
          sy_d = sy_q + MW'(rd_q.y);
          sz_d = sz_q + MW'(rd_q.z);
          added_d = added_q + CW'(1);
          idx_d = idx_q + CW'(1);
          state_d = S_RD;
        end else if (!have_q) begin
          have_d = 1'b1;
          bnum_d = num_q;  bden_d = den_q;  best_d = rd_q;
          idx_d = idx_q + CW'(1);
          state_d = S_RD;
        end else begin
          acc_d = '0;  i_d = '0;  j_d = 1'b0;
          opa_d = num_q;  opb_d = 64'(bden_q);
          op_d = OP_CMP1;  state_d = S_MUL;
        end
      end

      // saturate and present the result
      S_FIN: begin
        oe_d = (fe > EMAX) ? 30'h3FFF_FFFF : fe[29:0];
        ox_d = (fx > SMAX) ? SMAX[30:0] : (fx < SMIN) ? SMIN[30:0] : fx[30:0];
        oy_d = (fy > SMAX) ? SMAX[30:0] : (fy < SMIN) ? SMIN[30:0] : fy[30:0];
        oz_d = (fz > SMAX) ? SMAX[30:0] : (fz < SMIN) ? SMIN[30:0] : fz[30:0];
        on_d = (fn_x > XW'(127)) ? 7'd127 : fn_x[6:0];
        oo_d = ovf_q;
        rv_d = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_PN2;
      i_q     <= '0;
      j_q     <= 1'b0;
      pval_q  <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      min_q   <= prmc_pkg::MIN_ENERGY_RST;
      lim_q   <= prmc_pkg::COS_LIMIT_RST;
      all_q   <= 1'b1;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pval_q  <= pval_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      min_q   <= min_d;
      lim_q   <= lim_d;
      all_q   <= all_d;
      rv_q    <= rv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;  lhs_q <= lhs_d;  prod_q <= prod_d;  pshift_q <= pshift_d;
    opa_q <= opa_d;  opb_q <= opb_d;  t_q <= t_d;
    num_q <= num_d;  bnum_q <= bnum_d;  den_q <= den_d;  bden_q <= bden_d;
    px_q <= px_d;  py_q <= py_d;  pz_q <= pz_d;
    pn2_q <= pn2_d;  gn2_q <= gn2_d;
    have_q <= have_d;  best_q <= best_d;
    se_q <= se_d;  sx_q <= sx_d;  sy_q <= sy_d;  sz_q <= sz_d;
    added_q <= added_d;  idx_q <= idx_d;
    oe_q <= oe_d;  ox_q <= ox_d;  oy_q <= oy_d;  oz_q <= oz_d;
    on_q <= on_d;  oo_q <= oo_d;
  end

  // photon store write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= '{e: energy_i, x: mom_x_i, y: mom_y_i, z: mom_z_i};
    end
    if (state_q == S_RD) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  assign result_valid_o     = rv_q;
  assign corrected_energy_o = oe_q;
  assign corrected_x_o      = ox_q;
  assign corrected_y_o      = oy_q;
  assign corrected_z_o      = oz_q;
  assign photons_added_o    = on_q;
  assign store_overflowed_o = oo_q;

endmodule
